// ----- rtl/lfu_cache_table_defines.svh -----
// Assertion helpers for the file that checks this block.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lfu_pkg.sv -----
package lfu_pkg;

    // Request kinds.
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // Capacity register width and reset value.
    localparam int unsigned CFG_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // One request transfer.
    typedef struct packed {
        logic        kind;
        logic [31:0] lookup_key;
        logic [31:0] write_value;
    } t_req;

    // One response transfer.
    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_rsp;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] uses;
        logic [31:0] stamp;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

// ----- rtl/lfu_cache_table.sv -----
// Channel    Direction  Handshake                    Payload
// request    in         i_in_valid / o_in_ready      i_req  (lfu_pkg::t_req)
// response   out        o_out_valid / i_out_ready    o_rsp  (lfu_pkg::t_rsp)
// config     in         i_cfg_we (always taken)      i_cfg_data (capacity in use)
//
// A request is accepted in idle, reads each entry of the entry memory in the scan, passes
// a drain state for the read latency, then writes back and finishes; with capacity zero
// the scan and drain are skipped. Reset is synchronous and needs no clearing pass. A held
// response stalls the write-back of the next request and so the acceptance of later ones.
`include "lfu_cache_table_defines.svh"

module lfu_cache_table #(
    parameter int CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  lfu_pkg::t_req             i_req,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output lfu_pkg::t_rsp             o_rsp,
    input  logic                      i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0] i_cfg_data
);

    import lfu_pkg::*;

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW    = $clog2(CAPACITY + 1);
    localparam int CW    = (OW > CFG_W) ? OW : CFG_W;
    localparam int EW    = $bits(t_entry);

    // Control state.
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cap_cfg;
    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] n_valid;
    logic [OW-1:0]      r_occ;
    logic [31:0]        r_clock;
    logic               r_out_valid;
    logic               r_pend;
    logic [IW-1:0]      r_rd_idx;

    // Request and scan results.
    t_req               r_req;
    t_rsp               r_rsp;
    logic [IW-1:0]      r_pend_idx;
    logic               r_found;
    logic [IW-1:0]      r_match_idx;
    t_entry             r_match;
    logic               r_vic_found;
    logic [IW-1:0]      r_vic_idx;
    logic [31:0]        r_vic_key;
    logic [31:0]        r_vic_uses;
    logic [31:0]        r_vic_age;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;

    // Memory port.
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [EW-1:0]      ram_rdata_bits;
    t_entry             rd;

    // Finish-step signals.
    logic               in_fire;
    logic               fin_fire;
    logic               cap_zero;
    logic [CW-1:0]      cap_ext;
    logic [CW-1:0]      cap_eff;
    logic               is_put;
    logic               evict;
    logic               ins_ok;
    logic [IW-1:0]      ins_idx;
    logic [31:0]        hit_value;
    logic [31:0]        clock_next;
    logic [31:0]        rd_age;
    logic               rd_valid;
    t_rsp               n_rsp;

    lfu_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    assign rd = t_entry'(ram_rdata_bits);

    // Effective capacity, clamped to the table size.
    always_comb begin
        cap_ext  = CW'(r_cap_cfg);
        cap_eff  = (cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext;
        cap_zero = (r_cap_cfg == '0);
    end

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign ram_raddr  = r_rd_idx;
    assign clock_next = r_clock + 32'd1;
    assign rd_age     = r_clock - rd.stamp;
    assign rd_valid   = r_valid[r_pend_idx];

    // Next state, write-back and response.
    always_comb begin
        n_state   = r_state;
        fin_fire  = 1'b0;
        is_put    = (r_req.kind == KIND_PUT);
        hit_value = is_put ? r_req.write_value : r_match.value;
        evict     = !cap_zero && !r_found && is_put && r_vic_found
                    && (CW'(r_occ) >= cap_eff);
        ins_ok    = evict || r_free_found;
        ins_idx   = (evict && !(r_free_found && (r_free_idx < r_vic_idx)))
                    ? r_vic_idx : r_free_idx;

        // The victim leaves first; the new key may reuse its slot.
        n_valid = r_valid;
        if (evict) begin
            n_valid[r_vic_idx] = 1'b0;
        end
        if (ins_ok) begin
            n_valid[ins_idx] = 1'b1;
        end

        ram_we          = 1'b0;
        ram_waddr       = r_found ? r_match_idx : ins_idx;
        ram_wdata.key   = r_req.lookup_key;
        ram_wdata.value = r_found ? hit_value : r_req.write_value;
        ram_wdata.uses  = r_found ? ((r_match.uses == '1) ? r_match.uses
                                                          : r_match.uses + 32'd1)
                                  : 32'd1;
        ram_wdata.stamp = clock_next;

        n_rsp.hit         = !cap_zero && r_found;
        n_rsp.read_value  = (!cap_zero && r_found) ? hit_value : 32'd0;
        n_rsp.evicted     = evict;
        n_rsp.evicted_key = evict ? r_vic_key : 32'd0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = cap_zero ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_idx == IW'(CAPACITY - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    fin_fire = 1'b1;
                    ram_we   = !cap_zero && (r_found || (is_put && ins_ok));
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers: capacity, valid bits, occupancy, access clock, scan pointer, response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg   <= CAP_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_rd_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap_cfg <= i_cfg_data;
            end
            r_pend <= (r_state == ST_SCAN);
            if (in_fire) begin
                r_rd_idx <= '0;
            end else if (r_state == ST_SCAN && r_rd_idx != IW'(CAPACITY - 1)) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (fin_fire) begin
                if (!cap_zero) begin
                    r_clock <= clock_next;
                end
                if (!cap_zero && !r_found && is_put) begin
                    r_valid <= n_valid;
                    if (!evict && ins_ok) begin
                        r_occ <= r_occ + OW'(1);
                    end
                end
            end
        end
    end

    // Request capture, scan comparisons and the response register.
    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_rd_idx;
        if (in_fire) begin
            r_req        <= i_req;
            r_found      <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
        end
        if (r_pend) begin
            // First valid entry holding the key.
            if (rd_valid && !r_found && rd.key == r_req.lookup_key) begin
                r_found     <= 1'b1;
                r_match_idx <= r_pend_idx;
                r_match     <= rd;
            end
            // Lowest use count, then largest age; ties keep the lower slot.
            if (rd_valid && (!r_vic_found || rd.uses < r_vic_uses
                             || (rd.uses == r_vic_uses && rd_age > r_vic_age))) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= r_pend_idx;
                r_vic_key   <= rd.key;
                r_vic_uses  <= rd.uses;
                r_vic_age   <= rd_age;
            end
            // First empty slot.
            if (!rd_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_pend_idx;
            end
        end
        if (fin_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    // Checks.
    `LFU_ASSERT_SAME(a_occ_matches_valid, 1'b1, $countones(r_valid) == int'(r_occ), "bad occupancy")
    `LFU_ASSERT_NEXT(a_write_gives_rsp, ram_we, r_out_valid, "write-back without a response")
    `LFU_ASSERT_SAME(a_evict_not_hit, r_out_valid && r_rsp.evicted, !r_rsp.hit, "eviction on a hit")

endmodule

// ----- rtl/lfu_ram.sv -----
module lfu_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import lfu_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    localparam int DIRECTED_ROWS = 24;
    localparam int PHASES        = 9;
    localparam int HOLD_CYCLES   = 400;
    localparam int POOL_MAX      = 24;

    // Capacity and length of each random phase; zero and the top of the register are included.
    localparam int PHASE_CAP   [PHASES] = '{16, 1, 31, 0, 3, 16, 2, 9, 5};
    localparam int PHASE_ITEMS [PHASES] = '{150, 130, 150, 30, 150, 150, 130, 150, 140};

    // One line of the directed plan: either a capacity write or a request.
    typedef struct packed {
        logic       is_cfg;
        logic [4:0] cap;
        logic       fixed;
        t_req       req;
        t_rsp       rsp;
    } t_row;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_req       req;
    logic       out_valid;
    logic       out_ready;
    t_rsp       rsp;
    logic       cfg_we;
    logic [4:0] cfg_data;

    // Expected value for the request on offer, used in place of the prediction when set.
    logic use_fixed;
    t_rsp fixed_rsp;

    // Mirror of the cache contents used to predict every response.
    bit          mirror_valid [TABLE_DEPTH];
    logic [31:0] mirror_key   [TABLE_DEPTH];
    logic [31:0] mirror_value [TABLE_DEPTH];
    logic [31:0] mirror_uses  [TABLE_DEPTH];
    logic [31:0] mirror_stamp [TABLE_DEPTH];
    int unsigned mirror_fill;
    logic [31:0] mirror_clock;
    logic [4:0]  mirror_cap;

    t_rsp outcome_q[$];
    int   sent_cnt;
    int   received_cnt;
    int   fail_count;
    int   hits_seen;
    int   evictions_seen;
    bit   steady;
    bit   long_hold;

    t_row        directed_rows [DIRECTED_ROWS];
    logic [31:0] key_pool      [POOL_MAX];

    lfu_cache_table #(
        .CAPACITY (TABLE_DEPTH)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_req       (req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // 2 ns clock.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Works out the response to one request and updates the mirror as the cache would.
    function automatic t_rsp cache_outcome(input t_req r);
        t_rsp        result;
        int unsigned active;
        int          slot;
        int          victim;
        int          i;
        logic [31:0] age;
        logic [31:0] best_age;
        logic [31:0] best_uses;
        result = '0;
        active = (mirror_cap > TABLE_DEPTH) ? TABLE_DEPTH : mirror_cap;
        if (active == 0) begin
            return result;
        end

        // A present key is touched: new value on a put, then count and stamp.
        slot = -1;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && mirror_valid[i] && mirror_key[i] == r.lookup_key) slot = i;
        if (slot >= 0) begin
            if (r.kind == KIND_PUT) mirror_value[slot] = r.write_value;
            mirror_clock = mirror_clock + 1;
            if (mirror_uses[slot] != 32'hFFFF_FFFF) mirror_uses[slot] = mirror_uses[slot] + 1;
            mirror_stamp[slot] = mirror_clock;
            result.hit        = 1'b1;
            result.read_value = mirror_value[slot];
            return result;
        end

        if (r.kind == KIND_GET) begin
            mirror_clock = mirror_clock + 1;
            return result;
        end

        // A full table gives up its least used entry, the oldest one among equals.
        if (mirror_fill >= active) begin
            victim    = -1;
            best_age  = '0;
            best_uses = '0;
            for (i = 0; i < TABLE_DEPTH; i++) begin
                if (mirror_valid[i]) begin
                    age = mirror_clock - mirror_stamp[i];
                    if (victim < 0 || mirror_uses[i] < best_uses ||
                        (mirror_uses[i] == best_uses && age > best_age)) begin
                        victim    = i;
                        best_uses = mirror_uses[i];
                        best_age  = age;
                    end
                end
            end
            if (victim >= 0) begin
                result.evicted      = 1'b1;
                result.evicted_key  = mirror_key[victim];
                mirror_valid[victim] = 1'b0;
                mirror_fill--;
            end
        end

        // The new key goes into the lowest free slot with a count of one.
        mirror_clock = mirror_clock + 1;
        slot = -1;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && !mirror_valid[i]) slot = i;
        if (slot >= 0) begin
            mirror_valid[slot] = 1'b1;
            mirror_key[slot]   = r.lookup_key;
            mirror_value[slot] = r.write_value;
            mirror_uses[slot]  = 32'd1;
            mirror_stamp[slot] = mirror_clock;
            mirror_fill++;
        end
        return result;
    endfunction

    function automatic t_row cap_row(input logic [4:0] cap);
        t_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.cap    = cap;
        return row;
    endfunction

    function automatic t_row req_row(input logic kind, input logic [31:0] key,
                                     input logic [31:0] value);
        t_row row;
        row                 = '0;
        row.req.kind        = kind;
        row.req.lookup_key  = key;
        row.req.write_value = value;
        return row;
    endfunction

    function automatic t_row known_row(input logic kind, input logic [31:0] key,
                                       input logic [31:0] value, input logic hit,
                                       input logic [31:0] read_value, input logic evicted,
                                       input logic [31:0] evicted_key);
        t_row row;
        row                 = req_row(kind, key, value);
        row.fixed           = 1'b1;
        row.rsp.hit         = hit;
        row.rsp.read_value  = read_value;
        row.rsp.evicted     = evicted;
        row.rsp.evicted_key = evicted_key;
        return row;
    endfunction

    // Offers one request after an optional random gap and returns at its transfer.
    task automatic offer_request(input t_req r, input logic fixed, input t_rsp expected);
        while (!steady && $urandom_range(0, 99) < 17) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req       <= r;
        use_fixed <= fixed;
        fixed_rsp <= expected;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_cnt++;
    endtask

    // Writes the capacity once every outstanding response has come back.
    task automatic set_capacity(input logic [4:0] cap);
        in_valid <= 1'b0;
        while (received_cnt < sent_cnt) @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_data   <= cap;
        mirror_cap  = cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Response side: random back-pressure, plus one long hold-off that stalls the block.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // Predicts on every request transfer and checks every response transfer.
    always @(posedge clk) begin : response_check
        t_rsp want;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                want = cache_outcome(req);
                outcome_q.push_back(use_fixed ? fixed_rsp : want);
            end
            if (out_valid && out_ready) begin
                received_cnt++;
                if (rsp.hit) hits_seen++;
                if (rsp.evicted) evictions_seen++;
                if (outcome_q.size() == 0) begin
                    $error("response transfer with no request outstanding");
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (rsp.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
                        fail_count++;
                    end
                    if (rsp.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h", want.read_value,
                               rsp.read_value);
                        fail_count++;
                    end
                    if (rsp.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d", want.evicted, rsp.evicted);
                        fail_count++;
                    end
                    if (rsp.evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %h, got %h", want.evicted_key,
                               rsp.evicted_key);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Stimulus: directed plan, then random phases at several capacities.
    initial begin
        int   i;
        int   p;
        int   n;
        int   pool_n;
        t_row row;
        t_req r;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        req       <= '0;
        use_fixed <= 1'b0;
        fixed_rsp <= '0;
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
        for (i = 0; i < TABLE_DEPTH; i++) mirror_valid[i] = 1'b0;
        mirror_fill    = 0;
        mirror_clock   = '0;
        mirror_cap     = CAP_RESET;
        sent_cnt       = 0;
        received_cnt   = 0;
        fail_count     = 0;
        hits_seen      = 0;
        evictions_seen = 0;
        steady         = 1'b0;
        long_hold      = 1'b0;

        // Key extremes, overwrite, a disabled cache, eviction order and a shrunken capacity.
        directed_rows = '{
            known_row(KIND_GET, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0),
            known_row(KIND_PUT, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 32'h0),
            known_row(KIND_GET, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0),
            known_row(KIND_PUT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0),
            known_row(KIND_PUT, 32'h0, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b0, 32'h0),
            known_row(KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 32'h0),
            cap_row(5'd0),
            known_row(KIND_GET, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0),
            known_row(KIND_PUT, 32'h5, 32'h5, 1'b0, 32'h0, 1'b0, 32'h0),
            cap_row(5'd2),
            known_row(KIND_GET, 32'h5, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0),
            known_row(KIND_PUT, 32'h7, 32'h70, 1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF),
            known_row(KIND_PUT, 32'h8, 32'h80, 1'b0, 32'h0, 1'b1, 32'h7),
            req_row(KIND_GET, 32'h8, 32'h0),
            req_row(KIND_GET, 32'h8, 32'h0),
            req_row(KIND_PUT, 32'h9, 32'h90),
            cap_row(5'd31),
            req_row(KIND_PUT, 32'hA1, 32'hA1A1_A1A1),
            req_row(KIND_PUT, 32'hA2, 32'h5A5A_5A5A),
            cap_row(5'd1),
            req_row(KIND_PUT, 32'hB1, 32'hB1),
            req_row(KIND_GET, 32'hB1, 32'h0),
            req_row(KIND_PUT, 32'hB2, 32'hB2),
            req_row(KIND_GET, 32'h9, 32'h0)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                set_capacity(row.cap);
            end else begin
                offer_request(row.req, row.fixed, row.rsp);
            end
        end

        // Keys come mostly from a small pool sized to the capacity, so hits and evictions mix.
        for (p = 0; p < PHASES; p++) begin
            set_capacity(5'(PHASE_CAP[p]));
            steady = (p == 5);
            if (p == 1) long_hold = 1'b1;
            pool_n = ((PHASE_CAP[p] > TABLE_DEPTH) ? TABLE_DEPTH : PHASE_CAP[p]) + 3;
            for (i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
            for (n = 0; n < PHASE_ITEMS[p]; n++) begin
                r.kind        = ($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET;
                r.lookup_key  = ($urandom_range(0, 99) < 85) ?
                                key_pool[$urandom_range(0, pool_n - 1)] : $urandom;
                r.write_value = $urandom;
                offer_request(r, 1'b0, '0);
            end
        end

        // Drain, then allow the block to settle before the verdict.
        in_valid <= 1'b0;
        steady    = 1'b0;
        while (received_cnt < sent_cnt) @(posedge clk);
        repeat (40) @(posedge clk);
        if (outcome_q.size() != 0) begin
            $error("%0d expected responses never arrived", outcome_q.size());
            fail_count++;
        end
        $display("Run covered %0d requests and %0d responses with %0d hits and %0d evictions.",
                 sent_cnt, received_cnt, hits_seen, evictions_seen);
        $display("Capacities from 0 to 31 were used, with a %0d-cycle response hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("** lfu_cache_table: PASSED **");
        end else begin
            $display("** lfu_cache_table: FAILED **");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #1_000_000;
        $display("** lfu_cache_table: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_cache_table.sv
test/tb_top.sv
